@@ rtl/jls_pkg.sv @@
`default_nettype none

package jls_pkg;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DONE
	} jls_state_t;

	// per-cell sequencer phases: the first four name the neighbour whose read is issued, PH_WB the write-back
	typedef enum logic [2:0] {
		PH_UP,
		PH_DOWN,
		PH_LEFT,
		PH_RIGHT,
		PH_WB
	} jls_phase_t;

	// request codes on the input tuser
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_RUN   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// result kinds on the output tuser
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	// register word index (paddr[2])
	localparam logic REG_GRID_SIDE  = 1'b0;
	localparam logic REG_ITER_COUNT = 1'b1;

	// fixed field widths
	localparam int COORD_W    = 6;
	localparam int GS_W       = 7;
	localparam int ITER_W     = 16;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	// wide enough for any side up to 256
	localparam int SIDE_W     = 9;
	localparam int MIN_SIDE   = 3;

	localparam logic [GS_W-1:0]   GS_RESET   = 7'd64;
	localparam logic [ITER_W-1:0] ITER_RESET = 16'd1;

	// 32-bit signed limits for read saturation
	localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;

endpackage

`default_nettype wire

@@ rtl/jls_ram.sv @@
`default_nettype none

module jls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/jacobi_laplace_stencil.sv @@
`default_nettype none

// channel   dir  handshake        payload
// s_*       in   tvalid/tready    tuser: req_type; tdata: cell_row, cell_col, write_value
// m_*       out  tvalid/tready    tuser: result_kind; tdata: read_value
// apb       in   psel/penable     grid_side at 0x0, iteration_count at 0x4
//
// a write request goes into the current bank as it is accepted; a read result passes the
// registered memory read and then the output register. a run walks all MAX_SIDE*MAX_SIDE cells once
// per sweep, reading the four neighbours of each cell in turn through the single read port, then writing back
// the grid lives in two ping-pong memories; no clearing pass, cells are undefined until written
// reset clears control and registers only; a waiting result holds while m_tready is low

module jacobi_laplace_stencil #(
	parameter int MAX_SIDE    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [jls_pkg::IN_DATA_W-1:0]     s_tdata,   // cell_row[5:0], cell_col[11:6], write_value[43:12], zero[47:44]
	input  logic [1:0]                        s_tuser,   // req_type[1:0]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [jls_pkg::OUT_DATA_W-1:0]    m_tdata,   // read_value[31:0]
	output logic                              m_tuser,   // result_kind[0]
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [jls_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [jls_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [jls_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	import jls_pkg::*;

	localparam int IDX_W = $clog2(MAX_SIDE);
	localparam int AW    = 2 * IDX_W;
	localparam int DEPTH = 1 << AW;
	localparam int SUM_W = VALUE_WIDTH + 2;
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_SIDE - 1);
	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

	jls_state_t state_q, state_d;
	jls_phase_t phase_q;

	logic [GS_W-1:0]   gs_q;
	logic [ITER_W-1:0] iter_q;
	logic [ITER_W-1:0] sweep_q;
	logic              cur_q;
	logic [IDX_W-1:0]  row_q, col_q;
	logic [SIDE_W-1:0] lim_q;
	logic [SUM_W-1:0]  acc_q;
	logic              rd_in_q;

	logic                  out_valid_q;
	logic                  out_kind_q;
	logic [OUT_DATA_W-1:0] out_value_q;

	// input word fields
	logic [1:0]         req;
	logic [COORD_W-1:0] row_in, col_in;
	logic [31:0]        wval_in;
	logic               accept, in_inside;
	logic [AW-1:0]      host_addr;

	assign req     = s_tuser;
	assign row_in  = s_tdata[5:0];
	assign col_in  = s_tdata[11:6];
	assign wval_in = s_tdata[43:12];
	assign accept  = s_tvalid && s_tready;

	assign in_inside = (SIDE_W'(row_in) < SIDE_MAX) && (SIDE_W'(col_in) < SIDE_MAX);
	assign host_addr = {IDX_W'(row_in), IDX_W'(col_in)};

	// configuration port
	logic cfg_we;
	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_GRID_SIDE:  prdata = APB_DATA_W'(gs_q);
			REG_ITER_COUNT: prdata = APB_DATA_W'(iter_q);
			default:        prdata = '0;
		endcase
	end

	// active side clamped between MIN_SIDE and the storage
	logic [SIDE_W-1:0] side;
	always_comb begin
		if (gs_q < GS_W'(MIN_SIDE)) begin
			side = SIDE_W'(MIN_SIDE);
		end else if (SIDE_W'(gs_q) > SIDE_MAX) begin
			side = SIDE_MAX;
		end else begin
			side = SIDE_W'(gs_q);
		end
	end

	// walk position
	logic          last_cell, last_sweep, interior;
	logic [AW-1:0] center;
	assign last_cell  = (row_q == LAST_IDX) && (col_q == LAST_IDX);
	assign last_sweep = (ITER_W'(sweep_q + 1'b1) == iter_q);
	assign interior   = (row_q != '0) && (SIDE_W'(row_q) < lim_q)
	                 && (col_q != '0) && (SIDE_W'(col_q) < lim_q);
	assign center     = {row_q, col_q};

	// neighbour address; cells off the interior read themselves four times
	logic [AW-1:0] nb_addr;
	always_comb begin
		case (phase_q)
			PH_UP:    nb_addr = interior ? {IDX_W'(row_q - 1'b1), col_q} : center;
			PH_DOWN:  nb_addr = interior ? {IDX_W'(row_q + 1'b1), col_q} : center;
			PH_LEFT:  nb_addr = interior ? {row_q, IDX_W'(col_q - 1'b1)} : center;
			PH_RIGHT: nb_addr = interior ? {row_q, IDX_W'(col_q + 1'b1)} : center;
			default:  nb_addr = center;
		endcase
	end

	// memory read data and stencil arithmetic
	logic [VALUE_WIDTH-1:0] rdata0, rdata1, rd_data;
	logic [SUM_W-1:0]       rd_ext, sum_full;
	logic [VALUE_WIDTH-1:0] sweep_val, host_val;
	assign rd_data   = cur_q ? rdata1 : rdata0;
	assign rd_ext    = {{2{rd_data[VALUE_WIDTH-1]}}, rd_data};
	assign sum_full  = acc_q + rd_ext;
	// arithmetic shift right by two, floor of the quarter
	assign sweep_val = sum_full[SUM_W-1:2];
	assign host_val  = VALUE_WIDTH'($signed(wval_in));

	// read value saturated to 32 bits
	logic signed [63:0]    rd_wide;
	logic [OUT_DATA_W-1:0] rd_sat;
	assign rd_wide = {{(64 - VALUE_WIDTH){rd_data[VALUE_WIDTH-1]}}, rd_data};
	always_comb begin
		if (rd_wide > OUT_MAX) begin
			rd_sat = OUT_MAX[OUT_DATA_W-1:0];
		end else if (rd_wide < OUT_MIN) begin
			rd_sat = OUT_MIN[OUT_DATA_W-1:0];
		end else begin
			rd_sat = rd_wide[OUT_DATA_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req)
						REQ_RUN:  state_d = (iter_q == '0) ? ST_DONE : ST_SWEEP;
						REQ_READ: state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_SWEEP: begin
				if (phase_q == PH_WB && last_cell && last_sweep) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and memory control
	logic          host_we, sweep_we, we0, we1, out_load;
	logic [AW-1:0] raddr, waddr;
	always_comb begin
		s_tready = 1'b0;
		host_we  = 1'b0;
		sweep_we = 1'b0;
		out_load = 1'b0;
		raddr    = host_addr;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !out_valid_q || m_tready;
				host_we  = accept && (req == REQ_WRITE) && in_inside;
			end
			ST_READ: out_load = 1'b1;
			ST_SWEEP: begin
				raddr    = nb_addr;
				sweep_we = (phase_q == PH_WB);
			end
			ST_DONE: out_load = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	// host writes land in the current bank, sweeps write the other one
	assign we0   = (host_we && !cur_q) || (sweep_we && cur_q);
	assign we1   = (host_we && cur_q) || (sweep_we && !cur_q);
	assign waddr = sweep_we ? center : host_addr;

	logic [VALUE_WIDTH-1:0] wdata;
	assign wdata = sweep_we ? sweep_val : host_val;

	jls_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata0)
	);

	jls_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata1)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_UP;
			gs_q        <= GS_RESET;
			iter_q      <= ITER_RESET;
			sweep_q     <= '0;
			cur_q       <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (paddr[2])
					REG_GRID_SIDE:  gs_q   <= pwdata[GS_W-1:0];
					REG_ITER_COUNT: iter_q <= pwdata[ITER_W-1:0];
					default:        gs_q   <= gs_q;
				endcase
			end

			if (state_q == ST_IDLE && accept && req == REQ_RUN) begin
				sweep_q <= '0;
				row_q   <= '0;
				col_q   <= '0;
				phase_q <= PH_UP;
			end else if (state_q == ST_SWEEP) begin
				if (phase_q == PH_WB) begin
					phase_q <= PH_UP;
					if (last_cell) begin
						row_q   <= '0;
						col_q   <= '0;
						cur_q   <= !cur_q;
						sweep_q <= ITER_W'(sweep_q + 1'b1);
					end else if (col_q == LAST_IDX) begin
						col_q <= '0;
						row_q <= IDX_W'(row_q + 1'b1);
					end else begin
						col_q <= IDX_W'(col_q + 1'b1);
					end
				end else begin
					phase_q <= jls_phase_t'(phase_q + 3'd1);
				end
			end

			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			lim_q   <= side - SIDE_W'(1);
			rd_in_q <= in_inside;
		end

		// neighbour sum
		if (state_q == ST_SWEEP) begin
			case (phase_q) inside
				PH_DOWN:          acc_q <= rd_ext;
				PH_LEFT, PH_RIGHT: acc_q <= sum_full;
				default:          acc_q <= acc_q;
			endcase
		end

		if (state_q == ST_READ) begin
			out_kind_q  <= KIND_READ;
			out_value_q <= rd_in_q ? rd_sat : '0;
		end else if (state_q == ST_DONE) begin
			out_kind_q  <= KIND_RUN;
			out_value_q <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_kind_q;

`ifndef SYNTHESIS
	// a sweep never writes the bank it is reading from
	a_sweep_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !(cur_q ? we1 : we0))
		else $error("sweep wrote the current bank");

	// a result is only loaded into an empty output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q)
		else $error("result overwrote a waiting word");

	// the sweep count stays below the requested number while sweeping
	a_sweep_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (sweep_q < iter_q))
		else $error("sweep count ran past iteration count");

	// banks swap only after the last cell of a sweep is written back
	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != $past(cur_q)) |->
			($past(state_q) == ST_SWEEP && $past(phase_q) == PH_WB && $past(last_cell)))
		else $error("bank swap outside sweep end");
`endif

endmodule

`default_nettype wire

@@ test/jacobi_laplace_stencil_tb.sv @@
`timescale 1ns / 100ps

module jacobi_laplace_stencil_tb;
	import jls_pkg::*;

	localparam int GRID_MAX       = 64;
	localparam int CELL_COUNT     = GRID_MAX * GRID_MAX;
	// request code that the block drops without a result
	localparam logic [1:0] REQ_NOP = 2'd3;
	// every sweep walks the whole store
	localparam int SWEEP_CYCLES   = 5 * CELL_COUNT;
	localparam int RUN_SWEEPS_MAX = 2;
	localparam int HOLD_CYCLES    = 300;
	localparam int LONG_GAP       = 40;
	localparam int SETTLE_CYCLES  = 12;
	localparam int IDLE_LIMIT     = 4 * (SWEEP_CYCLES * RUN_SWEEPS_MAX + HOLD_CYCLES
		+ 2 * LONG_GAP + 64);
	localparam int ROUNDS         = 18;
	// corner of the grid that gets loaded; wider grids only see zero-sweep runs
	localparam int SPAN_MAX       = 10;
	localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;

	typedef struct {
		logic [1:0]         op;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [31:0]        value;
	} grid_req_t;

	typedef struct {
		logic                  kind;
		logic [OUT_DATA_W-1:0] value;
	} grid_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // cell_row[5:0], cell_col[11:6], write_value[43:12], zero[47:44]
	logic [1:0]            s_tuser = '0;   // req_type[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // read_value[31:0]
	logic                  m_tuser;        // result_kind[0]
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	jacobi_laplace_stencil uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// grid predictor state
	logic signed [31:0] model_grid [CELL_COUNT];
	logic signed [31:0] model_scratch [CELL_COUNT];
	logic [GS_W-1:0]    model_side = GS_RESET;
	logic [ITER_W-1:0]  model_iters = ITER_RESET;

	grid_result_t awaited_results [$];
	grid_req_t    request_queue [$];
	bit           cell_known [CELL_COUNT];
	int           error_count = 0;
	bit           sender_pauses = 1'b0;
	bit           receiver_pauses = 1'b0;
	int           holds_asked = 0;

	function automatic int clamp_side(input logic [GS_W-1:0] side);
		if (side < MIN_SIDE)
			return MIN_SIDE;
		if (side > GRID_MAX)
			return GRID_MAX;
		return int'(side);
	endfunction

	function automatic int pause_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, LONG_GAP);
	endfunction

	// one jacobi sweep over the interior, floor of a quarter of the 34-bit sum
	task automatic relax_once(input int n);
		int c;
		logic signed [33:0] acc;
		logic signed [33:0] quarter;
		for (int i = 1; i < n - 1; i++)
			for (int j = 1; j < n - 1; j++) begin
				c = i * GRID_MAX + j;
				acc = model_grid[c - GRID_MAX];
				acc = acc + model_grid[c + GRID_MAX];
				acc = acc + model_grid[c - 1];
				acc = acc + model_grid[c + 1];
				quarter = acc >>> 2;
				model_scratch[c] = quarter[31:0];
			end
		for (int i = 1; i < n - 1; i++)
			for (int j = 1; j < n - 1; j++)
				model_grid[i * GRID_MAX + j] = model_scratch[i * GRID_MAX + j];
	endtask

	// expected result of one accepted request word
	task automatic predict_request(input grid_req_t req);
		int idx;
		idx = int'(req.row) * GRID_MAX + int'(req.col);
		case (req.op)
			REQ_WRITE: model_grid[idx] = req.value;
			REQ_RUN: begin
				for (int k = 0; k < int'(model_iters); k++)
					relax_once(clamp_side(model_side));
				awaited_results.push_back('{KIND_RUN, '0});
			end
			REQ_READ: awaited_results.push_back('{KIND_READ, model_grid[idx]});
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("error: %s expected %h got %h at %0t", what, want, got, $realtime);
		error_count++;
	endtask

	// request driver
	int        send_gap = 0;
	grid_req_t on_offer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_request(on_offer);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					on_offer = request_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= on_offer.op;
					s_tdata <= {4'b0, on_offer.value, on_offer.col, on_offer.row};
					send_gap = sender_pauses ? pause_length() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random stalls and the long hold-off
	int           stall_left = 0;
	int           hold_left = 0;
	int           holds_done = 0;
	grid_result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected word", '0, m_tdata);
				end else begin
					want = awaited_results.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch("result kind", 32'(want.kind), 32'(m_tuser));
					if (m_tdata !== want.value)
						report_mismatch("read value", want.value, m_tdata);
				end
			end
			if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = (receiver_pauses && $urandom_range(0, 2) == 0) ? pause_length() : 0;
				m_tready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// watchdog on cycles without any accepted word or register access
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// register write: setup then access, taken at the access edge
	task automatic write_register(input logic reg_sel, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_sel == REG_GRID_SIDE)
			model_side = value[GS_W-1:0];
		else
			model_iters = value[ITER_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_queue.size() != 0 || s_tvalid || awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_request(input logic [1:0] op, input int row, input int col,
		input logic [31:0] value);
		grid_req_t req;
		req.op = op;
		req.row = row[COORD_W-1:0];
		req.col = col[COORD_W-1:0];
		req.value = value;
		if (op == REQ_WRITE)
			cell_known[row * GRID_MAX + col] = 1'b1;
		request_queue.push_back(req);
	endtask

	function automatic logic [31:0] random_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// read of a cell already written, mostly inside the active grid
	task automatic queue_known_read(input int n);
		int row;
		int col;
		int far_row;
		int far_col;
		row = $urandom_range(0, n - 1);
		col = $urandom_range(0, n - 1);
		far_row = $urandom_range(0, GRID_MAX - 1);
		far_col = $urandom_range(0, GRID_MAX - 1);
		if ($urandom_range(0, 2) == 0 && cell_known[far_row * GRID_MAX + far_col]) begin
			row = far_row;
			col = far_col;
		end
		queue_request(REQ_READ, row, col, $urandom());
	endtask

	// stimulus
	initial begin
		int side_val;
		int iter_val;
		int n;
		int span;
		bit do_run;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// smallest grid, zero sweeps first
		write_register(REG_GRID_SIDE, 32'd0);
		write_register(REG_ITER_COUNT, 32'd0);
		@(negedge clk);
		// two maxima and two minima round the centre: floor of a negative quarter
		queue_request(REQ_WRITE, 0, 0, '0);
		queue_request(REQ_WRITE, 0, 1, VAL_MAX);
		queue_request(REQ_WRITE, 0, 2, '1);
		queue_request(REQ_WRITE, 1, 0, VAL_MIN);
		queue_request(REQ_WRITE, 1, 1, 32'h1234_5678);
		queue_request(REQ_WRITE, 1, 2, VAL_MIN);
		queue_request(REQ_WRITE, 2, 0, 32'd1);
		queue_request(REQ_WRITE, 2, 1, VAL_MAX);
		queue_request(REQ_WRITE, 2, 2, 32'h0001_0000);
		queue_request(REQ_WRITE, 0, 63, VAL_MIN);
		queue_request(REQ_WRITE, 63, 0, VAL_MAX);
		queue_request(REQ_WRITE, 63, 63, 32'h0000_8000);
		// dropped request code with every field bit set
		queue_request(REQ_NOP, 63, 63, '1);
		queue_request(REQ_READ, 63, 63, '0);
		queue_request(REQ_READ, 0, 63, '0);
		queue_request(REQ_READ, 63, 0, '1);
		queue_request(REQ_RUN, 0, 0, '0);
		queue_request(REQ_READ, 1, 1, '0);
		wait_drained();
		write_register(REG_ITER_COUNT, 32'd1);
		@(negedge clk);
		queue_request(REQ_RUN, 63, 63, '1);
		queue_request(REQ_READ, 1, 1, '0);
		queue_request(REQ_READ, 0, 1, '0);

		// random rounds: load, overwrite, run, read back
		for (int round = 0; round < ROUNDS; round++) begin
			wait_drained();
			if (round == 0) begin
				side_val = 127;
			end else if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 5))
					0: side_val = 0;
					1: side_val = 1;
					2: side_val = 2;
					3: side_val = 64;
					4: side_val = 65;
					default: side_val = 127;
				endcase
			end else begin
				side_val = $urandom_range(3, SPAN_MAX);
			end
			iter_val = (round == 1) ? 65535 : $urandom_range(round == 0 ? 1 : 0, RUN_SWEEPS_MAX);
			do_run = (round == 0) || (round != 1 && $urandom_range(0, 3) != 0);
			sender_pauses = ($urandom_range(0, 3) != 0);
			receiver_pauses = ($urandom_range(0, 3) != 0);
			n = clamp_side(side_val[GS_W-1:0]);
			// only a corner gets loaded, so wide grids take zero-sweep runs
			span = (n > SPAN_MAX) ? SPAN_MAX : n;
			if (n > SPAN_MAX)
				iter_val = 0;
			write_register(REG_GRID_SIDE, side_val);
			write_register(REG_ITER_COUNT, iter_val);
			@(negedge clk);

			// every cell of the swept grid gets a value before it is swept
			for (int r = 0; r < span; r++)
				for (int c = 0; c < span; c++)
					if (!cell_known[r * GRID_MAX + c])
						queue_request(REQ_WRITE, r, c, random_value());
			repeat ($urandom_range(3, 7))
				queue_request(REQ_WRITE, $urandom_range(0, span - 1),
					$urandom_range(0, span - 1), random_value());
			case ($urandom_range(0, 2))
				0: queue_request(REQ_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom());
				1: queue_request(REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
					random_value());
				default: queue_known_read(span);
			endcase
			// receiver holds off while reads keep coming
			if (round == 3) begin
				holds_asked++;
				repeat (20) queue_known_read(span);
			end
			repeat ($urandom_range(1, 3)) queue_known_read(span);
			if (do_run)
				queue_request(REQ_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
			repeat ($urandom_range(4, 8)) queue_known_read(span);
		end

		wait_drained();
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
